/* design/rps_pkg.sv */
// shared types, constants and helpers for the rle palette sprite decoder
package rps_pkg;

  // command queue between parser and pixel generator
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // operation codes carried by one queued command
  typedef enum logic [1:0] {
    CMD_PAL_WRITE = 2'd0,
    CMD_SHADOW    = 2'd1,
    CMD_PIXEL     = 2'd2,
    CMD_FRAME_END = 2'd3
  } cmd_op_t;

  // one command: a palette write or a run of results
  typedef struct packed {
    cmd_op_t      op;
    logic [5:0]   count;
    logic [15:0]  x;
    logic [15:0]  y;
    logic [7:0]   idx;
    logic [23:0]  rgb;
  } cmd_t;

  localparam logic [7:0] ALPHA_SHADOW = 8'd128;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // coordinate add that sticks at the top of the 16 bit range
  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [5:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {11'b0, b};
    sat_add = s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

/* design/rps_front.sv */
// byte parser: walks the frame header and control bytes and issues commands
module rps_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  logic           kind,
  input  logic           frame_start,
  input  logic [7:0]     data_byte,
  input  logic [7:0]     palette_index,
  input  logic [7:0]     palette_red,
  input  logic [7:0]     palette_green,
  input  logic [7:0]     palette_blue,
  output logic           push,
  output rps_pkg::cmd_t  cmd
);

  // control byte operation field
  localparam logic [1:0] CTL_SKIP   = 2'b00;
  localparam logic [1:0] CTL_SHADOW = 2'b01;
  localparam logic [1:0] CTL_LIT    = 2'b10;
  localparam logic [1:0] CTL_FILL   = 2'b11;

  typedef enum logic [2:0] {
    PH_IDLE, PH_PREFIX, PH_YLO, PH_YHI, PH_HLO, PH_HHI, PH_CTRL, PH_RUN
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] column, column_next;
  logic [15:0] row, row_next;
  logic [15:0] rows_left, rows_left_next;
  logic [5:0]  literals_left, literals_left_next;
  logic [5:0]  fill_count, fill_count_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;
  logic [5:0]  cnt;
  logic [15:0] rows_dec;

  assign cnt      = data_byte[5:0];
  assign rows_dec = rows_left - 16'd1;

  // next parser state and the command caused by this request
  always_comb begin
    phase_next         = phase;
    column_next        = column;
    row_next           = row;
    rows_left_next     = rows_left;
    literals_left_next = literals_left;
    fill_count_next    = fill_count;
    low_byte_hold_next = low_byte_hold;
    push               = 1'b0;
    cmd.op             = rps_pkg::CMD_PAL_WRITE;
    cmd.count          = 6'd1;
    cmd.x              = column;
    cmd.y              = row;
    cmd.idx            = data_byte;
    cmd.rgb            = {palette_red, palette_green, palette_blue};
    if (fire) begin
      if (!kind) begin
        // palette entry write goes through the queue to keep order with reads
        push    = 1'b1;
        cmd.idx = palette_index;
      end else if (frame_start) begin
        phase_next         = PH_PREFIX;
        column_next        = 16'd0;
        row_next           = 16'd0;
        rows_left_next     = 16'd0;
        literals_left_next = 6'd0;
        fill_count_next    = 6'd0;
        low_byte_hold_next = 8'd0;
      end else begin
        case (phase)
          PH_IDLE: begin
          end
          PH_PREFIX: phase_next = PH_YLO;
          PH_YLO: begin
            low_byte_hold_next = data_byte;
            phase_next         = PH_YHI;
          end
          PH_YHI: begin
            row_next   = {data_byte, low_byte_hold};
            phase_next = PH_HLO;
          end
          PH_HLO: begin
            low_byte_hold_next = data_byte;
            phase_next         = PH_HHI;
          end
          PH_HHI: begin
            rows_left_next = {data_byte, low_byte_hold};
            column_next    = 16'd0;
            if ({data_byte, low_byte_hold} == 16'd0) begin
              push       = 1'b1;
              cmd.op     = rps_pkg::CMD_FRAME_END;
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_CTRL;
            end
          end
          PH_CTRL: begin
            if (data_byte == 8'd0) begin
              // end of row
              row_next       = rps_pkg::sat_add(row, 6'd1);
              column_next    = 16'd0;
              rows_left_next = rows_dec;
              if (rows_dec == 16'd0) begin
                push       = 1'b1;
                cmd.op     = rps_pkg::CMD_FRAME_END;
                phase_next = PH_IDLE;
              end
            end else begin
              case (data_byte[7:6])
                CTL_SKIP: column_next = rps_pkg::sat_add(column, cnt);
                CTL_SHADOW: begin
                  push        = (cnt != 6'd0);
                  cmd.op      = rps_pkg::CMD_SHADOW;
                  cmd.count   = cnt;
                  column_next = rps_pkg::sat_add(column, cnt);
                end
                CTL_LIT: begin
                  if (cnt != 6'd0) begin
                    literals_left_next = cnt;
                    phase_next         = PH_RUN;
                  end
                end
                CTL_FILL: begin
                  literals_left_next = 6'd0;
                  fill_count_next    = cnt;
                  phase_next         = PH_RUN;
                end
                default: begin
                end
              endcase
            end
          end
          PH_RUN: begin
            cmd.op = rps_pkg::CMD_PIXEL;
            if (literals_left != 6'd0) begin
              // one literal index byte
              push               = 1'b1;
              column_next        = rps_pkg::sat_add(column, 6'd1);
              literals_left_next = literals_left - 6'd1;
              if (literals_left == 6'd1) phase_next = PH_CTRL;
            end else begin
              // fill index byte
              push            = (fill_count != 6'd0);
              cmd.count       = fill_count;
              column_next     = rps_pkg::sat_add(column, fill_count);
              fill_count_next = 6'd0;
              phase_next      = PH_CTRL;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      column        <= 16'd0;
      row           <= 16'd0;
      rows_left     <= 16'd0;
      literals_left <= 6'd0;
      fill_count    <= 6'd0;
      low_byte_hold <= 8'd0;
    end else begin
      phase         <= phase_next;
      column        <= column_next;
      row           <= row_next;
      rows_left     <= rows_left_next;
      literals_left <= literals_left_next;
      fill_count    <= fill_count_next;
      low_byte_hold <= low_byte_hold_next;
    end
  end

endmodule

/* design/rps_queue.sv */
// short command fifo between parser and pixel generator
module rps_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rps_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output rps_pkg::cmd_t  head
);

  rps_pkg::cmd_t             slots [rps_pkg::QDEPTH];
  logic [rps_pkg::QPTR_W-1:0] wr_ptr;
  logic [rps_pkg::QPTR_W-1:0] rd_ptr;
  logic [rps_pkg::QPTR_W:0]   fill;

  assign full      = (fill == (rps_pkg::QPTR_W + 1)'(rps_pkg::QDEPTH));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

/* design/rps_back.sv */
// pixel generator: owns the palette memory and drains commands into results
module rps_back #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    image_width,
  input  logic [15:0]    image_height,
  input  logic           q_not_empty,
  input  rps_pkg::cmd_t  head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           pixel_valid,
  output logic [15:0]    pixel_x,
  output logic [15:0]    pixel_y,
  output logic [7:0]     red,
  output logic [7:0]     green,
  output logic [7:0]     blue,
  output logic [7:0]     alpha,
  output logic           clipped,
  output logic           frame_end,
  output logic           last
);

  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  typedef enum logic {B_IDLE, B_EMIT} bstate_t;

  logic [23:0]      pal_mem [PALETTE_ENTRIES];
  logic [23:0]      rd_data;
  bstate_t          state;
  rps_pkg::cmd_op_t cur_op;
  logic [5:0]       remaining;
  logic [15:0]      cur_x;
  logic [15:0]      cur_y;
  logic             cur_in_range;
  logic             head_in_range;
  logic             take;
  logic             fire;
  logic             final_px;
  logic             px_valid;
  logic [15:0]      px_x;
  logic [15:0]      px_y;
  logic [23:0]      px_rgb;
  logic [7:0]       px_alpha;

  assign head_in_range = ({1'b0, head.idx} < 9'(PALETTE_ENTRIES));
  assign take          = !out_valid || out_ready;
  assign fire          = (state == B_EMIT) && take;
  assign final_px      = fire && (remaining == 6'd1);
  assign pop           = q_not_empty && ((state == B_IDLE) || final_px);

  // palette memory, written and read in command order
  always_ff @(posedge clk) begin
    if (pop && head.op == rps_pkg::CMD_PAL_WRITE && head_in_range)
      pal_mem[head.idx[IDX_W-1:0]] <= head.rgb;
    if (pop) rd_data <= pal_mem[head.idx[IDX_W-1:0]];
  end

  // fields of the result now being produced
  always_comb begin
    px_valid = 1'b1;
    px_x     = cur_x;
    px_y     = cur_y;
    px_rgb   = 24'd0;
    px_alpha = rps_pkg::ALPHA_OPAQUE;
    case (cur_op)
      rps_pkg::CMD_SHADOW: px_alpha = rps_pkg::ALPHA_SHADOW;
      rps_pkg::CMD_PIXEL: px_rgb = cur_in_range ? rd_data : 24'd0;
      rps_pkg::CMD_FRAME_END: begin
        px_valid = 1'b0;
        px_x     = 16'd0;
        px_y     = 16'd0;
        px_alpha = 8'd0;
      end
      default: begin
      end
    endcase
  end

  // run sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (fire) begin
        pixel_valid <= px_valid;
        pixel_x     <= px_x;
        pixel_y     <= px_y;
        red         <= px_rgb[23:16];
        green       <= px_rgb[15:8];
        blue        <= px_rgb[7:0];
        alpha       <= px_alpha;
        clipped     <= px_valid && ((px_x >= image_width) || (px_y >= image_height));
        frame_end   <= (cur_op == rps_pkg::CMD_FRAME_END);
        last        <= (remaining == 6'd1);
      end
      // a new run is loaded, else the current one advances
      if (pop && head.op != rps_pkg::CMD_PAL_WRITE) begin
        state        <= B_EMIT;
        cur_op       <= head.op;
        remaining    <= head.count;
        cur_x        <= head.x;
        cur_y        <= head.y;
        cur_in_range <= head_in_range;
      end else if (fire) begin
        remaining <= remaining - 6'd1;
        cur_x     <= rps_pkg::sat_add(cur_x, 6'd1);
        if (remaining == 6'd1) state <= B_IDLE;
      end
    end
  end

endmodule

/* design/rle_palette_sprite_decoder_top.sv */
// top level of the rle palette sprite decoder
// One request (a palette write or one compressed frame byte) is taken per cycle
// while the four-entry command queue has room. Each palette write and each request
// that produces results turns into one command. An idle pixel generator loads a
// queued command in the following cycle and registers each result at the output.
// It emits one result per cycle while out_ready does not stall it, one per pixel
// of a shadow or fill run and one per literal byte; the next command is loaded
// with the final result of the one before. A palette write loads no run; the next
// command waits for an idle generator. Input stalls once the queue fills behind a
// long run. The palette is read once when a command is loaded. Palette entries are
// undefined until written; clipping uses the width and height registers, which the
// user must write only while the block is idle; the block does not enforce this.
module rle_palette_sprite_decoder_top #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic        frame_start,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  palette_index,
  input  logic [7:0]  palette_red,
  input  logic [7:0]  palette_green,
  input  logic [7:0]  palette_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pixel_valid,
  output logic [15:0] pixel_x,
  output logic [15:0] pixel_y,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic        clipped,
  output logic        frame_end,
  output logic        last
);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  logic [15:0]   image_width;
  logic [15:0]   image_height;
  logic          in_fire;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_not_empty;
  rps_pkg::cmd_t push_cmd;
  rps_pkg::cmd_t head;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 16'd64;
      image_height <= 16'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rps_front u_front (
    .clk           (clk),
    .rst           (rst),
    .fire          (in_fire),
    .kind          (kind),
    .frame_start   (frame_start),
    .data_byte     (data_byte),
    .palette_index (palette_index),
    .palette_red   (palette_red),
    .palette_green (palette_green),
    .palette_blue  (palette_blue),
    .push          (push),
    .cmd           (push_cmd)
  );

  rps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  rps_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .q_not_empty  (q_not_empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_valid  (pixel_valid),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .clipped      (clipped),
    .frame_end    (frame_end),
    .last         (last)
  );

  // frame end marker is a lone, non-pixel result
  a_frame_end_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> !pixel_valid && last && !clipped)
    else $error("frame end result carries a pixel or is not last");

  // every non-pixel result is a frame end marker
  a_nonpixel_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pixel_valid |-> frame_end)
    else $error("non-pixel result without frame end");

  // nothing is popped from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_not_empty)
    else $error("command popped from empty queue");

endmodule

/* tb/sv/rps_tb_pkg.sv */
`timescale 1ns / 1ps
// codes shared by the sprite decoder checker and its stimulus
package rps_tb_pkg;

  // request kinds
  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_FRAME   = 1'b1;

  // configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // a zero control byte closes the current row
  localparam logic [7:0] END_OF_ROW = 8'h00;

  // top two bits of a control byte
  typedef enum logic [1:0] {
    RUN_SKIP    = 2'd0,
    RUN_SHADOW  = 2'd1,
    RUN_LITERAL = 2'd2,
    RUN_FILL    = 2'd3
  } run_op_t;

endpackage

/* tb/sv/rps_checker.sv */
`timescale 1ns / 1ps
// pixel predictor and result comparison for the rle palette sprite decoder
module rps_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        kind,
  input  logic        frame_start,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  palette_index,
  input  logic [7:0]  palette_red,
  input  logic [7:0]  palette_green,
  input  logic [7:0]  palette_blue,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        pixel_valid,
  input  logic [15:0] pixel_x,
  input  logic [15:0] pixel_y,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  alpha,
  input  logic        clipped,
  input  logic        frame_end,
  input  logic        last,
  output int          errors,
  output int          pending
);

  typedef enum logic [2:0] {
    PARSE_IDLE,
    PARSE_PREFIX,
    PARSE_ROW_LO,
    PARSE_ROW_HI,
    PARSE_COUNT_LO,
    PARSE_COUNT_HI,
    PARSE_CONTROL,
    PARSE_RUN
  } parse_phase_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic        clipped;
    logic        frame_end;
    logic        last;
  } pixel_t;

  // decoder state as seen from outside
  logic [23:0]  colors [256];
  parse_phase_t phase;
  logic [15:0]  col;
  logic [15:0]  row_num;
  logic [15:0]  rows_left;
  logic [5:0]   literals_left;
  logic [5:0]   fill_count;
  logic [7:0]   low_hold;
  logic [15:0]  image_width;
  logic [15:0]  image_height;

  pixel_t expected_pixels [$];
  pixel_t batch [$];
  pixel_t got;
  pixel_t want;

  initial begin
    errors  = 0;
    pending = 0;
  end

  // add with the coordinate sticking at the top of its range
  function automatic logic [15:0] clamp_add(input logic [15:0] a, input logic [6:0] n);
    if (a > 16'hFFFF - {9'd0, n}) return 16'hFFFF;
    return a + {9'd0, n};
  endfunction

  task push_pixel(input logic [23:0] rgb, input logic [7:0] a);
    pixel_t p;
    p             = '0;
    p.pixel_valid = 1'b1;
    p.x           = col;
    p.y           = row_num;
    p.r           = rgb[23:16];
    p.g           = rgb[15:8];
    p.b           = rgb[7:0];
    p.a           = a;
    p.clipped     = (col >= image_width) || (row_num >= image_height);
    batch.insert(batch.size(), p);
    col = clamp_add(col, 7'd1);
  endtask

  task push_frame_marker();
    pixel_t p;
    p           = '0;
    p.frame_end = 1'b1;
    batch.insert(batch.size(), p);
  endtask

  // work out the pixels one accepted request produces
  task decode_request(input logic k, input logic st, input logic [7:0] b,
                      input logic [7:0] idx, input logic [23:0] rgb);
    pixel_t p;
    int     i;
    if (k == rps_tb_pkg::KIND_PALETTE) begin
      colors[idx] = rgb;
    end else if (st) begin
      phase         = PARSE_PREFIX;
      col           = '0;
      row_num       = '0;
      rows_left     = '0;
      literals_left = '0;
      fill_count    = '0;
      low_hold      = '0;
    end else begin
      case (phase)
        PARSE_PREFIX: phase = PARSE_ROW_LO;
        PARSE_ROW_LO: begin
          low_hold = b;
          phase    = PARSE_ROW_HI;
        end
        PARSE_ROW_HI: begin
          row_num = {b, low_hold};
          phase   = PARSE_COUNT_LO;
        end
        PARSE_COUNT_LO: begin
          low_hold = b;
          phase    = PARSE_COUNT_HI;
        end
        PARSE_COUNT_HI: begin
          rows_left = {b, low_hold};
          col       = '0;
          if (rows_left == 16'd0) begin
            push_frame_marker();
            phase = PARSE_IDLE;
          end else begin
            phase = PARSE_CONTROL;
          end
        end
        PARSE_CONTROL: begin
          if (b == rps_tb_pkg::END_OF_ROW) begin
            row_num   = clamp_add(row_num, 7'd1);
            col       = '0;
            rows_left = rows_left - 16'd1;
            if (rows_left == 16'd0) begin
              push_frame_marker();
              phase = PARSE_IDLE;
            end
          end else begin
            case (rps_tb_pkg::run_op_t'(b[7:6]))
              rps_tb_pkg::RUN_SKIP: col = clamp_add(col, {1'b0, b[5:0]});
              rps_tb_pkg::RUN_SHADOW: begin
                for (i = 0; i < int'(b[5:0]); i++)
                  push_pixel(24'h0, rps_pkg::ALPHA_SHADOW);
              end
              rps_tb_pkg::RUN_LITERAL: begin
                if (b[5:0] != 6'd0) begin
                  literals_left = b[5:0];
                  phase         = PARSE_RUN;
                end
              end
              default: begin
                literals_left = '0;
                fill_count    = b[5:0];
                phase         = PARSE_RUN;
              end
            endcase
          end
        end
        PARSE_RUN: begin
          if (literals_left != 6'd0) begin
            push_pixel(colors[b], rps_pkg::ALPHA_OPAQUE);
            literals_left = literals_left - 6'd1;
            if (literals_left == 6'd0) phase = PARSE_CONTROL;
          end else begin
            for (i = 0; i < int'(fill_count); i++)
              push_pixel(colors[b], rps_pkg::ALPHA_OPAQUE);
            fill_count = '0;
            phase      = PARSE_CONTROL;
          end
        end
        default: ;
      endcase
    end
    // mark the final pixel of this request and queue the lot
    if (batch.size() > 0) begin
      p      = batch.pop_back();
      p.last = 1'b1;
      batch.insert(batch.size(), p);
    end
    while (batch.size() > 0) expected_pixels.insert(expected_pixels.size(), batch.pop_front());
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    if (rst) begin
      phase         = PARSE_IDLE;
      col           = '0;
      row_num       = '0;
      rows_left     = '0;
      literals_left = '0;
      fill_count    = '0;
      low_hold      = '0;
      image_width   = 16'd64;
      image_height  = 16'd64;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == rps_tb_pkg::REG_IMAGE_WIDTH) image_width = cfg_data;
        else image_height = cfg_data;
      end
      // compare the delivered result with the oldest prediction
      if (out_valid && out_ready) begin
        got = {pixel_valid, pixel_x, pixel_y, red, green, blue, alpha, clipped, frame_end, last};
        if (expected_pixels.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("%0t: result with nothing expected: v=%0b x=%0d y=%0d end=%0b last=%0b",
                     $time, got.pixel_valid, got.x, got.y, got.frame_end, got.last);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            errors = errors + 1;
            if (errors <= 10) begin
              $display("%0t: expected v=%0b x=%0d y=%0d rgba=%h %h %h %h clip=%0b end=%0b last=%0b",
                       $time, want.pixel_valid, want.x, want.y, want.r, want.g, want.b, want.a,
                       want.clipped, want.frame_end, want.last);
              $display("%0t: actual   v=%0b x=%0d y=%0d rgba=%h %h %h %h clip=%0b end=%0b last=%0b",
                       $time, got.pixel_valid, got.x, got.y, got.r, got.g, got.b, got.a,
                       got.clipped, got.frame_end, got.last);
            end
          end
        end
      end
      if (in_valid && in_ready)
        decode_request(kind, frame_start, data_byte, palette_index,
                       {palette_red, palette_green, palette_blue});
    end
    pending = expected_pixels.size();
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// testbench top: clock, reset, request stimulus and verdict for the sprite decoder
module testbench;

  localparam int ITEM_TARGET    = 280;
  localparam int HOLD_CYCLES    = 600;
  localparam int SETTLE_CYCLES  = 16;
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic        frame_start;
  logic [7:0]  data_byte;
  logic [7:0]  palette_index;
  logic [7:0]  palette_red;
  logic [7:0]  palette_green;
  logic [7:0]  palette_blue;
  logic        out_valid;
  logic        out_ready;
  logic        pixel_valid;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        clipped;
  logic        frame_end;
  logic        last;

  int   errors;
  int   pending;
  int   idle_cycles;
  int   items_done;
  bit   hold_req;
  bit   recv_calm;
  bit   sender_calm;
  bit   parser_idle;
  bit   pal_set [256];
  logic [7:0] pal_known [$];
  logic [7:0] frame_bytes [$];

  initial clk = 1'b0;
  always #1 clk = ~clk;

  rle_palette_sprite_decoder_top u_top (.*);

  rps_checker u_chk (.*);

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_index();
    return pal_known[$urandom_range(0, pal_known.size() - 1)];
  endfunction

  // append one byte to the frame being built
  task add_byte(input logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endtask

  // present one request and hold it until the decoder takes it
  task offer(input logic k, input logic st, input logic [7:0] b, input logic [7:0] idx,
             input logic [23:0] rgb);
    int gap;
    if (!sender_calm && $urandom_range(0, 99) < 30) begin
      gap      = gap_len();
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= k;
    frame_start   <= st;
    data_byte     <= b;
    palette_index <= idx;
    palette_red   <= rgb[23:16];
    palette_green <= rgb[15:8];
    palette_blue  <= rgb[7:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task pal_write(input logic [7:0] idx, input logic [23:0] rgb);
    offer(rps_tb_pkg::KIND_PALETTE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
          idx, rgb);
    if (!pal_set[idx]) begin
      pal_set[idx] = 1'b1;
      pal_known.insert(pal_known.size(), idx);
    end
    items_done++;
  endtask

  task frame_byte(input logic st, input logic [7:0] b);
    offer(rps_tb_pkg::KIND_FRAME, st, b, 8'($urandom_range(0, 255)), 24'($urandom));
  endtask

  // start byte, second prefix byte, start row and row count
  task frame_header(input logic [15:0] y0, input logic [15:0] nrows);
    frame_bytes.delete();
    add_byte(8'($urandom_range(0, 255)));
    add_byte(8'($urandom_range(0, 255)));
    add_byte(y0[7:0]);
    add_byte(y0[15:8]);
    add_byte(nrows[7:0]);
    add_byte(nrows[15:8]);
  endtask

  // a few random runs and the row terminator
  task add_row();
    int                  ops;
    int                  cnt;
    int                  r;
    rps_tb_pkg::run_op_t op;
    ops = $urandom_range(0, 4);
    repeat (ops) begin
      op = rps_tb_pkg::run_op_t'($urandom_range(0, 3));
      r  = $urandom_range(0, 99);
      case (op)
        rps_tb_pkg::RUN_SKIP: cnt = $urandom_range(1, 63);
        rps_tb_pkg::RUN_SHADOW:
          cnt = r < 20 ? 0 : r < 90 ? $urandom_range(1, 6) : $urandom_range(7, 63);
        rps_tb_pkg::RUN_LITERAL:
          cnt = r < 15 ? 0 : r < 85 ? $urandom_range(1, 4) : $urandom_range(5, 12);
        default:
          cnt = r < 10 ? 0 : r < 75 ? $urandom_range(1, 8) : $urandom_range(30, 63);
      endcase
      add_byte({op, 6'(cnt)});
      if (op == rps_tb_pkg::RUN_LITERAL) repeat (cnt) add_byte(pick_index());
      else if (op == rps_tb_pkg::RUN_FILL) add_byte(pick_index());
    end
    add_byte(rps_tb_pkg::END_OF_ROW);
  endtask

  // send the first cut bytes of the built frame, with stray palette writes
  task play_frame(input int cut);
    int k;
    for (k = 0; k < cut; k++) begin
      if (k > 0 && $urandom_range(0, 19) == 0)
        pal_write(8'($urandom_range(0, 255)), 24'($urandom));
      frame_byte(k == 0, frame_bytes[k]);
      items_done++;
    end
  endtask

  // stop offering until every predicted pixel has come out
  task drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task resize(input logic [15:0] w, input logic [15:0] h);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= rps_tb_pkg::REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= rps_tb_pkg::REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mix of whole frames, cut frames, palette writes and idle noise
  task run_random(input int goal);
    int          pick;
    int          r;
    logic [15:0] y0;
    logic [15:0] nrows;
    while (items_done < goal) begin
      pick        = $urandom_range(0, 99);
      sender_calm = ($urandom_range(0, 3) == 0);
      if (pick < 12) begin
        repeat ($urandom_range(1, 3)) pal_write(8'($urandom_range(0, 255)), 24'($urandom));
      end else if (pick < 17 && parser_idle) begin
        frame_byte(1'b0, 8'($urandom_range(0, 255)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) y0 = 16'($urandom_range(0, 80));
        else if (r < 85) y0 = 16'hFFFD + 16'($urandom_range(0, 2));
        else y0 = 16'($urandom_range(0, 65535));
        nrows = ($urandom_range(0, 99) < 8) ? 16'd0 : 16'($urandom_range(1, 3));
        frame_header(y0, nrows);
        repeat (nrows) add_row();
        if (pick < 27) begin
          play_frame($urandom_range(1, frame_bytes.size() - 1));
          parser_idle = 1'b0;
        end else begin
          play_frame(frame_bytes.size());
          parser_idle = 1'b1;
        end
      end
      if ($urandom_range(0, 9) == 0) drain();
    end
  endtask

  // result side: random stalls, calm stretches and one long hold-off
  initial begin
    out_ready = 1'b0;
    recv_calm = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if ($urandom_range(0, 149) == 0) recv_calm = !recv_calm;
        if (recv_calm || $urandom_range(0, 99) < 70) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (gap_len() - 1) @(negedge clk);
        end
      end
    end
  end

  // give up when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // request stimulus and verdict
  initial begin
    int          ph;
    logic [15:0] w;
    logic [15:0] h;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = rps_tb_pkg::REG_IMAGE_WIDTH;
    cfg_data      = '0;
    in_valid      = 1'b0;
    kind          = rps_tb_pkg::KIND_PALETTE;
    frame_start   = 1'b0;
    data_byte     = '0;
    palette_index = '0;
    palette_red   = '0;
    palette_green = '0;
    palette_blue  = '0;
    hold_req      = 1'b0;
    sender_calm   = 1'b1;
    parser_idle   = 1'b1;
    items_done    = 0;
    idle_cycles   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extreme colors, ignored idle byte, every run kind incl. zero counts
    pal_write(8'h00, 24'hFFFFFF);
    pal_write(8'hFF, 24'h000000);
    pal_write(8'h5A, 24'hA53CC3);
    frame_byte(1'b0, 8'h33);
    frame_header(16'd62, 16'd2);
    add_byte({rps_tb_pkg::RUN_SHADOW, 6'd2});
    add_byte({rps_tb_pkg::RUN_LITERAL, 6'd1});
    add_byte(8'hFF);
    add_byte({rps_tb_pkg::RUN_FILL, 6'd3});
    add_byte(8'h00);
    add_byte({rps_tb_pkg::RUN_SHADOW, 6'd0});
    add_byte({rps_tb_pkg::RUN_LITERAL, 6'd0});
    add_byte({rps_tb_pkg::RUN_FILL, 6'd0});
    add_byte(8'h5A);
    add_byte({rps_tb_pkg::RUN_SKIP, 6'd63});
    add_byte({rps_tb_pkg::RUN_SHADOW, 6'd1});
    add_byte(rps_tb_pkg::END_OF_ROW);
    add_byte(rps_tb_pkg::END_OF_ROW);
    play_frame(frame_bytes.size());

    // random phases under different clip sizes
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin w = 16'd0; h = 16'd0; end
        1: begin w = 16'hFFFF; h = 16'hFFFF; end
        2: begin w = 16'($urandom_range(1, 100)); h = 16'($urandom_range(1, 100)); end
        default: begin w = 16'($urandom_range(0, 65535)); h = 16'd1; end
      endcase
      resize(w, h);
      if (ph == 1) begin
        // long fill runs against a stalled receiver so the input backs up
        hold_req    = 1'b1;
        sender_calm = 1'b1;
        frame_header(16'd0, 16'd2);
        repeat (2) begin
          repeat (4) begin
            add_byte({rps_tb_pkg::RUN_FILL, 6'd63});
            add_byte(pick_index());
          end
          add_byte(rps_tb_pkg::END_OF_ROW);
        end
        play_frame(frame_bytes.size());
        parser_idle = 1'b1;
      end
      run_random(ITEM_TARGET * (ph + 1) / 4);
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/rps_pkg.sv
design/rps_front.sv
design/rps_queue.sv
design/rps_back.sv
design/rle_palette_sprite_decoder_top.sv
tb/sv/rps_tb_pkg.sv
tb/sv/rps_checker.sv
tb/sv/testbench.sv
